>>> rtl/core/imhtq_pkg.sv
// ----------------------------------------------------------------------------
// imhtq_pkg
// Types and codes shared by the indexed min-heap timer queue.
// ----------------------------------------------------------------------------
package imhtq_pkg;

  localparam int unsigned FuncBits   = 2;
  localparam int unsigned JobBits    = 8;
  localparam int unsigned TsBits     = 32;
  localparam int unsigned StatusBits = 2;
  localparam int unsigned CountBits  = 9;

  localparam logic [FuncBits-1:0] FUNC_PUSH   = 2'd0;
  localparam logic [FuncBits-1:0] FUNC_POP    = 2'd1;
  localparam logic [FuncBits-1:0] FUNC_REMOVE = 2'd2;

  localparam logic [StatusBits-1:0] STATUS_OK   = 2'd0;
  localparam logic [StatusBits-1:0] STATUS_MISS = 2'd1;
  localparam logic [StatusBits-1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic [FuncBits-1:0] func;
    logic [JobBits-1:0]  job_id;
    logic [TsBits-1:0]   timestamp;
  } req_t;

  typedef struct packed {
    logic [StatusBits-1:0] status;
    logic [JobBits-1:0]    out_job;
    logic [TsBits-1:0]     out_timestamp;
    logic                  top_valid;
    logic [JobBits-1:0]    top_job;
    logic [TsBits-1:0]     top_timestamp;
    logic [CountBits-1:0]  count;
  } rsp_t;

endpackage

>>> rtl/core/indexed_min_heap_timer_queue_core.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_timer_queue_core
// Indexed binary min-heap of timed jobs with push, pop and remove by job id.
// ----------------------------------------------------------------------------
// channel | dir | handshake           | payload
// req     | in  | req_valid_i/ready_o | imhtq_pkg::req_t
// rsp     | out | rsp_valid_o/ready_i | imhtq_pkg::rsp_t
//
// One transfer at a time: the position table is read, then for pop or remove
// an entry is taken out; the entry is sifted up or down a level at a time,
// placed, the top is read and the response raised. The single-port heap RAM
// serializes these steps. After reset a clearing pass sweeps the position RAM;
// no request is taken during it. A stalled response holds its register and
// blocks the next request.
// ----------------------------------------------------------------------------
module indexed_min_heap_timer_queue_core #(
  parameter int unsigned CAPACITY  = 256,
  parameter int unsigned JOB_IDS   = 256,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  imhtq_pkg::req_t   req_i,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output imhtq_pkg::rsp_t   rsp_o
);

  localparam int unsigned SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned JW = (JOB_IDS > 1) ? $clog2(JOB_IDS) : 1;
  localparam int unsigned TW = TIME_BITS;
  localparam int unsigned EW = JW + TW;
  localparam int unsigned PW = SW + 1;

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_POSRD = 5'd2;
  localparam logic [4:0] S_DEC   = 5'd3;
  localparam logic [4:0] S_RDA   = 5'd4;
  localparam logic [4:0] S_RDAW  = 5'd5;
  localparam logic [4:0] S_RDL   = 5'd6;
  localparam logic [4:0] S_RDLW  = 5'd7;
  localparam logic [4:0] S_TAKE  = 5'd8;
  localparam logic [4:0] S_UPRD  = 5'd9;
  localparam logic [4:0] S_UPCMP = 5'd10;
  localparam logic [4:0] S_UPW2  = 5'd11;
  localparam logic [4:0] S_DNRDL = 5'd12;
  localparam logic [4:0] S_DNRDR = 5'd13;
  localparam logic [4:0] S_DNCMP = 5'd14;
  localparam logic [4:0] S_DNW2  = 5'd15;
  localparam logic [4:0] S_TOPRD = 5'd16;
  localparam logic [4:0] S_TOPW  = 5'd17;
  localparam logic [4:0] S_RSP   = 5'd18;
  localparam logic [4:0] S_PW1   = 5'd19;
  localparam logic [4:0] S_DNRW  = 5'd20;

  localparam logic [1:0] M_UPDN = 2'd0;
  localparam logic [1:0] M_DNUP = 2'd1;

  logic [EW-1:0] heap_mem [CAPACITY];
  logic [PW-1:0] pos_mem  [JOB_IDS];

  logic          h_we, h_re;
  logic [SW-1:0] h_addr;
  logic [EW-1:0] h_wdata, h_rdata_q;
  logic          p_we, p_re;
  logic [JW-1:0] p_waddr, p_raddr;
  logic [PW-1:0] p_wdata, p_rdata_q;

  always_ff @(posedge clk_i) begin
    if (h_we) heap_mem[h_addr] <= h_wdata;
    if (h_re) h_rdata_q <= heap_mem[h_addr];
  end

  always_ff @(posedge clk_i) begin
    if (p_we) pos_mem[p_waddr] <= p_wdata;
    if (p_re) p_rdata_q <= pos_mem[p_raddr];
  end

  logic [4:0]           state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [JW-1:0]        clr_q, clr_d;
  imhtq_pkg::req_t      req_q, req_d;
  logic [SW-1:0]        i_q, i_d;
  logic [SW-1:0]        c_q, c_d;
  logic [EW-1:0]        cur_q, cur_d;
  logic [EW-1:0]        oth_q, oth_d;
  logic [EW-1:0]        lft_q, lft_d;
  logic [EW-1:0]        gone_q, gone_d;
  logic [1:0]           mode_q, mode_d;
  logic                 second_q, second_d;
  logic [SW-1:0]        start_q, start_d;
  logic                 rv_q, rv_d;
  imhtq_pkg::rsp_t      rsp_q, rsp_d;

  logic                 job_ok;
  logic [JW-1:0]        jid;
  logic [TW-1:0]        ts_in;
  logic [CW:0]          lchild, rchild;
  logic [SW-1:0]        parent;
  logic [TW-1:0]        ts_cur, ts_oth, ts_lft;

  assign jid    = JW'(req_q.job_id);
  assign job_ok = {{(32 - imhtq_pkg::JobBits){1'b0}}, req_q.job_id} < 32'(JOB_IDS);
  assign ts_in  = TW'(req_q.timestamp);
  assign lchild = {i_q, 1'b1} + (CW + 1)'(0);
  assign rchild = lchild + (CW + 1)'(1);
  assign parent = SW'(({1'b0, i_q} - (SW + 1)'(1)) >> 1);
  assign ts_cur = cur_q[TW-1:0];
  assign ts_oth = oth_q[TW-1:0];
  assign ts_lft = lft_q[TW-1:0];

  assign req_ready_o = (state_q == S_IDLE) && !rv_q;
  assign rsp_valid_o = rv_q;
  assign rsp_o       = rsp_q;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    clr_d    = clr_q;
    req_d    = req_q;
    i_d      = i_q;
    c_d      = c_q;
    cur_d    = cur_q;
    oth_d    = oth_q;
    lft_d    = lft_q;
    gone_d   = gone_q;
    mode_d   = mode_q;
    second_d = second_q;
    start_d  = start_q;
    rv_d     = rv_q;
    rsp_d    = rsp_q;
    h_we     = 1'b0;
    h_re     = 1'b0;
    h_addr   = i_q;
    h_wdata  = cur_q;
    p_we     = 1'b0;
    p_re     = 1'b0;
    p_waddr  = cur_q[EW-1:TW];
    p_raddr  = jid;
    p_wdata  = {1'b1, i_q};

    if (rv_q && rsp_ready_i) rv_d = 1'b0;

    case (state_q)
      S_CLR: begin
        p_we    = 1'b1;
        p_waddr = clr_q;
        p_wdata = '0;
        clr_d   = clr_q + JW'(1);
        if (32'(clr_q) == JOB_IDS - 1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid_i && req_ready_o) begin
          req_d   = req_i;
          p_re    = 1'b1;
          p_raddr = JW'(req_i.job_id);
          state_d = S_POSRD;
        end
      end
      S_POSRD: state_d = S_DEC;
      S_DEC: begin
        rsp_d.status        = imhtq_pkg::STATUS_MISS;
        rsp_d.out_job       = '0;
        rsp_d.out_timestamp = '0;
        state_d             = S_TOPRD;
        case (req_q.func)
          imhtq_pkg::FUNC_PUSH: begin
            rsp_d.out_job = req_q.job_id;
            if (!job_ok) begin
              state_d = S_TOPRD;
            end else if (p_rdata_q[PW-1]) begin
              rsp_d.status        = imhtq_pkg::STATUS_OK;
              rsp_d.out_timestamp = imhtq_pkg::TsBits'(ts_in);
              i_d    = p_rdata_q[SW-1:0];
              cur_d  = {jid, ts_in};
              mode_d = M_UPDN;
              second_d = 1'b0;
              start_d  = p_rdata_q[SW-1:0];
              state_d  = S_UPRD;
            end else if (32'(cnt_q) >= CAPACITY) begin
              rsp_d.status        = imhtq_pkg::STATUS_FULL;
              rsp_d.out_timestamp = imhtq_pkg::TsBits'(ts_in);
            end else begin
              rsp_d.status        = imhtq_pkg::STATUS_OK;
              rsp_d.out_timestamp = imhtq_pkg::TsBits'(ts_in);
              i_d      = SW'(cnt_q);
              cur_d    = {jid, ts_in};
              cnt_d    = cnt_q + CW'(1);
              mode_d   = M_UPDN;
              second_d = 1'b1;
              state_d  = S_UPRD;
            end
          end
          imhtq_pkg::FUNC_POP: begin
            if (cnt_q != '0) begin
              i_d     = '0;
              state_d = S_RDA;
            end
          end
          imhtq_pkg::FUNC_REMOVE: begin
            rsp_d.out_job = req_q.job_id;
            if (job_ok && p_rdata_q[PW-1]
                && CW'(p_rdata_q[SW-1:0]) < cnt_q) begin
              i_d     = p_rdata_q[SW-1:0];
              state_d = S_RDA;
            end
          end
          default: state_d = S_TOPRD;
        endcase
      end
      S_RDA: begin
        h_re    = 1'b1;
        state_d = S_RDAW;
      end
      S_RDAW: begin
        gone_d  = h_rdata_q;
        state_d = S_RDL;
      end
      S_RDL: begin
        h_re    = 1'b1;
        h_addr  = SW'(cnt_q - CW'(1));
        state_d = S_RDLW;
      end
      S_RDLW: begin
        cur_d   = h_rdata_q;
        p_we    = 1'b1;
        p_waddr = gone_q[EW-1:TW];
        p_wdata = '0;
        rsp_d.status        = imhtq_pkg::STATUS_OK;
        rsp_d.out_job       = imhtq_pkg::JobBits'(gone_q[EW-1:TW]);
        rsp_d.out_timestamp = imhtq_pkg::TsBits'(gone_q[TW-1:0]);
        cnt_d   = cnt_q - CW'(1);
        state_d = S_TAKE;
      end
      S_TAKE: begin
        if (CW'(i_q) < cnt_q) begin
          mode_d   = M_DNUP;
          second_d = 1'b0;
          start_d  = i_q;
          state_d  = S_DNRDL;
        end else begin
          state_d = S_TOPRD;
        end
      end
      S_UPRD: begin
        if (i_q == '0) begin
          state_d = S_PW1;
        end else begin
          h_re    = 1'b1;
          h_addr  = parent;
          state_d = S_UPCMP;
        end
      end
      S_UPCMP: begin
        oth_d = h_rdata_q;
        if (h_rdata_q[TW-1:0] > ts_cur) begin
          h_we    = 1'b1;
          h_addr  = i_q;
          h_wdata = h_rdata_q;
          p_we    = 1'b1;
          p_waddr = h_rdata_q[EW-1:TW];
          p_wdata = {1'b1, i_q};
          i_d     = parent;
          state_d = S_UPRD;
        end else begin
          state_d = S_PW1;
        end
      end
      S_PW1: begin
        h_we    = 1'b1;
        h_addr  = i_q;
        h_wdata = cur_q;
        p_we    = 1'b1;
        p_waddr = cur_q[EW-1:TW];
        p_wdata = {1'b1, i_q};
        state_d = S_UPW2;
      end
      S_UPW2: begin
        if (!second_q && mode_q == M_UPDN) begin
          second_d = 1'b1;
          state_d  = S_DNRDL;
        end else if (!second_q && mode_q == M_DNUP && i_q == start_q) begin
          second_d = 1'b1;
          i_d      = start_q;
          state_d  = S_UPRD;
        end else begin
          state_d = S_TOPRD;
        end
      end
      S_DNRDL: begin
        if (lchild >= (CW + 1)'(cnt_q)) begin
          state_d = S_PW1;
        end else begin
          h_re    = 1'b1;
          h_addr  = SW'(lchild);
          c_d     = SW'(lchild);
          state_d = S_DNRDR;
        end
      end
      S_DNRDR: begin
        lft_d = h_rdata_q;
        oth_d = h_rdata_q;
        if (rchild < (CW + 1)'(cnt_q)) begin
          h_re    = 1'b1;
          h_addr  = SW'(rchild);
          state_d = S_DNRW;
        end else begin
          state_d = S_DNCMP;
        end
      end
      S_DNRW: begin
        if (h_rdata_q[TW-1:0] < ts_lft) begin
          oth_d = h_rdata_q;
          c_d   = SW'(rchild);
        end
        state_d = S_DNCMP;
      end
      S_DNCMP: begin
        if (ts_oth < ts_cur) begin
          h_we    = 1'b1;
          h_addr  = i_q;
          h_wdata = oth_q;
          p_we    = 1'b1;
          p_waddr = oth_q[EW-1:TW];
          p_wdata = {1'b1, i_q};
          i_d     = c_q;
          state_d = S_DNRDL;
        end else begin
          state_d = S_PW1;
        end
      end
      S_TOPRD: begin
        h_re    = 1'b1;
        h_addr  = '0;
        state_d = S_TOPW;
      end
      S_TOPW: begin
        rsp_d.count = imhtq_pkg::CountBits'(cnt_q);
        if (cnt_q != '0) begin
          rsp_d.top_valid     = 1'b1;
          rsp_d.top_job       = imhtq_pkg::JobBits'(h_rdata_q[EW-1:TW]);
          rsp_d.top_timestamp = imhtq_pkg::TsBits'(h_rdata_q[TW-1:0]);
        end else begin
          rsp_d.top_valid     = 1'b0;
          rsp_d.top_job       = '0;
          rsp_d.top_timestamp = '0;
        end
        state_d = S_RSP;
      end
      S_RSP: begin
        rv_d    = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      cnt_q   <= '0;
      clr_q   <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      clr_q   <= clr_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    i_q      <= i_d;
    c_q      <= c_d;
    cur_q    <= cur_d;
    oth_q    <= oth_d;
    lft_q    <= lft_d;
    gone_q   <= gone_d;
    mode_q   <= mode_d;
    second_q <= second_d;
    start_q  <= start_d;
    rsp_q    <= rsp_d;
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= CAPACITY) else $error("heap count above capacity");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_ready_o |-> (state_q == S_IDLE)) else $error("ready outside idle");
  a_rsp_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (rsp_o.top_valid == (rsp_o.count != '0)))
    else $error("top valid disagrees with count");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> (cnt_q == $past(cnt_q))) else $error("count moved in idle");

endmodule

>>> sim/indexed_min_heap_timer_queue_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_min_heap_timer_queue_core_test
// Drives push, pop, remove and unused-code requests into the heap timer queue, predicts
// each response with an indexed min-heap kept in the testbench, and compares
// every response field with the oldest prediction.
// ----------------------------------------------------------------------------
module indexed_min_heap_timer_queue_core_test;

  localparam int unsigned Capacity   = 256;
  localparam int unsigned JobIds     = 256;
  localparam int unsigned NumRandom  = 1120;
  localparam int unsigned CycleLimit = 1000000;
  localparam logic [imhtq_pkg::FuncBits-1:0] FuncUnused = 2'd3;

  class heap_scoreboard;
    logic [imhtq_pkg::JobBits-1:0] slot_job [Capacity];
    logic [imhtq_pkg::TsBits-1:0]  slot_ts  [Capacity];
    bit                            job_here [JobIds];
    int unsigned                   job_slot [JobIds];
    int unsigned                   fill;
    imhtq_pkg::rsp_t               pending [$];
    int unsigned                   errors;

    function new();
      fill = 0;
      errors = 0;
      foreach (job_here[i]) job_here[i] = 0;
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      logic [imhtq_pkg::JobBits-1:0] j;
      logic [imhtq_pkg::TsBits-1:0]  t;
      j = slot_job[a]; slot_job[a] = slot_job[b]; slot_job[b] = j;
      t = slot_ts[a];  slot_ts[a]  = slot_ts[b];  slot_ts[b]  = t;
      job_slot[slot_job[a]] = a;
      job_slot[slot_job[b]] = b;
    endfunction

    function void sift_up(int unsigned i);
      int unsigned p;
      while (i > 0) begin
        p = (i - 1) / 2;
        if (slot_ts[p] > slot_ts[i]) begin
          swap_slots(i, p);
          i = p;
        end else begin
          break;
        end
      end
    endfunction

    function void sift_down(int unsigned i);
      int unsigned c;
      while (2 * i + 1 < fill) begin
        c = 2 * i + 1;
        if (c + 1 < fill && slot_ts[c + 1] < slot_ts[c]) c = c + 1;
        if (slot_ts[c] < slot_ts[i]) begin
          swap_slots(c, i);
          i = c;
        end else begin
          break;
        end
      end
    endfunction

    function void extract(int unsigned s, inout imhtq_pkg::rsp_t r);
      r.out_job = slot_job[s];
      r.out_timestamp = slot_ts[s];
      swap_slots(s, fill - 1);
      fill = fill - 1;
      job_here[r.out_job] = 0;
      if (s < fill) begin
        sift_down(s);
        sift_up(s);
      end
      r.status = imhtq_pkg::STATUS_OK;
    endfunction

    function void note_request(imhtq_pkg::req_t q);
      imhtq_pkg::rsp_t r;
      int unsigned s;
      r = '0;
      r.status = imhtq_pkg::STATUS_MISS;
      case (q.func)
        imhtq_pkg::FUNC_PUSH: begin
          r.out_job = q.job_id;
          r.out_timestamp = q.timestamp;
          if (job_here[q.job_id]) begin
            s = job_slot[q.job_id];
            slot_ts[s] = q.timestamp;
            sift_up(s);
            sift_down(job_slot[q.job_id]);
            r.status = imhtq_pkg::STATUS_OK;
          end else if (fill >= Capacity) begin
            r.status = imhtq_pkg::STATUS_FULL;
          end else begin
            slot_job[fill] = q.job_id;
            slot_ts[fill] = q.timestamp;
            job_here[q.job_id] = 1;
            job_slot[q.job_id] = fill;
            fill = fill + 1;
            sift_up(fill - 1);
            r.status = imhtq_pkg::STATUS_OK;
          end
        end
        imhtq_pkg::FUNC_POP: begin
          if (fill > 0) extract(0, r);
        end
        imhtq_pkg::FUNC_REMOVE: begin
          r.out_job = q.job_id;
          if (job_here[q.job_id]) extract(job_slot[q.job_id], r);
        end
        default: ;
      endcase
      if (fill > 0) begin
        r.top_valid = 1'b1;
        r.top_job = slot_job[0];
        r.top_timestamp = slot_ts[0];
      end
      r.count = imhtq_pkg::CountBits'(fill);
      pending.insert(pending.size(), r);
    endfunction

    function void check_response(imhtq_pkg::rsp_t got);
      imhtq_pkg::rsp_t w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected response %p", $time, got);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.status !== w.status)
        $display("%0t: status exp %0d got %0d", $time, w.status, got.status);
      if (got.out_job !== w.out_job)
        $display("%0t: out_job exp %0d got %0d", $time, w.out_job, got.out_job);
      if (got.out_timestamp !== w.out_timestamp)
        $display("%0t: out_timestamp exp %h got %h", $time, w.out_timestamp,
                 got.out_timestamp);
      if (got.top_valid !== w.top_valid)
        $display("%0t: top_valid exp %0d got %0d", $time, w.top_valid, got.top_valid);
      if (got.top_job !== w.top_job)
        $display("%0t: top_job exp %0d got %0d", $time, w.top_job, got.top_job);
      if (got.top_timestamp !== w.top_timestamp)
        $display("%0t: top_timestamp exp %h got %h", $time, w.top_timestamp,
                 got.top_timestamp);
      if (got.count !== w.count)
        $display("%0t: count exp %0d got %0d", $time, w.count, got.count);
      if (got !== w) errors++;
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            req_valid_i;
  logic            req_ready_o;
  imhtq_pkg::req_t req_i;
  logic            rsp_valid_o;
  logic            rsp_ready_i;
  imhtq_pkg::rsp_t rsp_o;

  heap_scoreboard board;
  bit             calm;
  bit             stall_request;
  bit             hold_used;
  int unsigned    hold_cycles;
  int unsigned    cycles = 0;

  indexed_min_heap_timer_queue_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic send_request(logic [imhtq_pkg::FuncBits-1:0] f,
                              logic [imhtq_pkg::JobBits-1:0] j,
                              logic [imhtq_pkg::TsBits-1:0] t);
    imhtq_pkg::req_t q;
    q.func = f;
    q.job_id = j;
    q.timestamp = t;
    while (!calm && $urandom_range(0, 99) < 11) begin
      req_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i <= q;
    do @(posedge clk_i); while (!req_ready_o);
    board.note_request(q);
  endtask

  function automatic logic [imhtq_pkg::TsBits-1:0] pick_time();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 15);
      1: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
      default: return $urandom();
    endcase
  endfunction

  // receiver: random stalls plus a long hold-off that blocks new requests
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ready_i <= 1'b0;
      hold_cycles <= 0;
      hold_used   <= 1'b0;
    end else begin
      if (rsp_valid_o && rsp_ready_i) board.check_response(rsp_o);
      if (stall_request && !hold_used) begin
        hold_used   <= 1'b1;
        hold_cycles <= 300;
        rsp_ready_i <= 1'b0;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        rsp_ready_i <= 1'b0;
      end else begin
        rsp_ready_i <= calm || ($urandom_range(0, 99) >= 11);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("indexed_min_heap_timer_queue_core_test: done, errors");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    int unsigned f;
    board = new();
    calm = 0;
    stall_request = 0;
    rst_ni = 1'b0;
    req_valid_i = 1'b0;
    req_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_request(imhtq_pkg::FUNC_POP, 8'd0, 32'd0);
    send_request(imhtq_pkg::FUNC_REMOVE, 8'd255, 32'd0);
    send_request(imhtq_pkg::FUNC_PUSH, 8'd0, 32'hFFFF_FFFF);
    send_request(imhtq_pkg::FUNC_PUSH, 8'd255, 32'd0);
    send_request(imhtq_pkg::FUNC_PUSH, 8'd85, 32'hAAAA_5555);
    send_request(imhtq_pkg::FUNC_PUSH, 8'd170, 32'h5555_AAAA);
    send_request(imhtq_pkg::FUNC_PUSH, 8'd7, 32'd0);
    send_request(imhtq_pkg::FUNC_PUSH, 8'd255, 32'd100);
    send_request(imhtq_pkg::FUNC_REMOVE, 8'd170, 32'd0);
    send_request(imhtq_pkg::FUNC_REMOVE, 8'd170, 32'd0);
    send_request(FuncUnused, 8'd255, 32'hFFFF_FFFF);
    send_request(imhtq_pkg::FUNC_POP, 8'd9, 32'd0);
    send_request(imhtq_pkg::FUNC_POP, 8'd0, 32'd0);
    send_request(imhtq_pkg::FUNC_POP, 8'd0, 32'd0);
    send_request(imhtq_pkg::FUNC_POP, 8'd0, 32'd0);
    send_request(imhtq_pkg::FUNC_POP, 8'd0, 32'd0);

    // fill to capacity, then update queued jobs, with a long stall on the response side
    stall_request = 1;
    for (n = 0; n < 256; n++) send_request(imhtq_pkg::FUNC_PUSH, n[7:0], pick_time());
    send_request(imhtq_pkg::FUNC_PUSH, 8'd3, 32'd1);
    for (n = 0; n < 4; n++) send_request(imhtq_pkg::FUNC_PUSH, 8'd0, pick_time());
    calm = 1;
    for (n = 0; n < 300; n++)
      send_request(imhtq_pkg::FUNC_REMOVE, 8'($urandom_range(0, 255)), 32'd0);
    calm = 0;

    for (n = 0; n < NumRandom; n++) begin
      if (n == 600) calm = 1;
      if (n == 900) calm = 0;
      f = $urandom_range(0, 99);
      if (f < 45)
        send_request(imhtq_pkg::FUNC_PUSH, 8'($urandom_range(0, 63)), pick_time());
      else if (f < 70)
        send_request(imhtq_pkg::FUNC_POP, 8'($urandom()), 32'($urandom()));
      else if (f < 97)
        send_request(imhtq_pkg::FUNC_REMOVE, 8'($urandom_range(0, 63)), 32'($urandom()));
      else
        send_request(FuncUnused, 8'($urandom()), 32'($urandom()));
    end
    req_valid_i <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("indexed_min_heap_timer_queue_core_test: done, clean");
    end else begin
      $display("indexed_min_heap_timer_queue_core_test: done, errors");
    end
    $finish;
  end

endmodule
